[design/cfa_pkg.sv]
// Package for the compensated float accumulator: word types, constants
// and the binary32 round-to-nearest-even adder function. No dependencies.
package cfa_pkg;

   localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [31:0] POS_INF   = 32'h7F80_0000;
   localparam logic [31:0] POS_ZERO  = 32'h0000_0000;

   typedef struct packed {
      logic [31:0] sample_bits;
      logic        restart;
   } req_word_type;

   typedef struct packed {
      logic [31:0] sum_bits;
      logic [31:0] compensation_bits;
   } rsp_word_type;

   function automatic logic f32_is_nan(input logic [31:0] x);
      return x[30:0] > POS_INF[30:0];
   endfunction

   function automatic logic f32_is_inf(input logic [31:0] x);
      return x[30:0] == POS_INF[30:0];
   endfunction

   function automatic logic [4:0] lead_shift(input logic [27:0] m);
      logic [4:0] n;
      n = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (m[i]) begin
            n = 5'(26 - i);
         end
      end
      if (m[27] || m[26]) begin
         n = 5'd0;
      end
      return n;
   endfunction

   function automatic logic [31:0] f32_add(input logic [31:0] a_in,
                                           input logic [31:0] b_in);
      logic [31:0] a, b, res;
      logic        sa, sb, sticky, rnd;
      logic [8:0]  ea, eb, e, sh, d;
      logic [27:0] ma, mb, m, lost_mask;
      logic [24:0] mr;
      logic [4:0]  lz;
      logic [2:0]  low;
      a = a_in;
      b = b_in;
      if (a_in[30:0] < b_in[30:0]) begin
         a = b_in;
         b = a_in;
      end
      sa = a[31];
      sb = b[31];
      ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
      eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
      ma = {1'b0, a[30:23] != 8'd0, a[22:0], 3'b000};
      mb = {1'b0, b[30:23] != 8'd0, b[22:0], 3'b000};
      d = ea - eb;
      if (d >= 9'd27) begin
         mb = {27'd0, mb != 28'd0};
      end else begin
         lost_mask = (28'd1 << d[4:0]) - 28'd1;
         sticky = (mb & lost_mask) != 28'd0;
         mb = (mb >> d[4:0]) | {27'd0, sticky};
      end
      e = ea;
      if (sa == sb) begin
         m = ma + mb;
         if (m[27]) begin
            m = {1'b0, m[27:2], m[1] | m[0]};
            e = e + 9'd1;
         end
      end else begin
         m = ma - mb;
         lz = lead_shift(m);
         sh = ({4'd0, lz} < e - 9'd1) ? {4'd0, lz} : e - 9'd1;
         m = m << sh[4:0];
         e = e - sh;
      end
      low = m[2:0];
      rnd = (low > 3'd4) || (low == 3'd4 && m[3]);
      mr = {1'b0, m[26:3]} + {24'd0, rnd};
      if (mr[24]) begin
         mr = mr >> 1;
         e = e + 9'd1;
      end
      if (!mr[23]) begin
         e = 9'd0;
      end
      if (e >= 9'd255) begin
         res = {sa, POS_INF[30:0]};
      end else begin
         res = {sa, e[7:0], mr[22:0]};
      end
      if (sa != sb && m == 28'd0) begin
         res = POS_ZERO;
      end
      if (f32_is_inf(b_in)) begin
         res = b_in;
      end
      if (f32_is_inf(a_in)) begin
         res = a_in;
      end
      if (f32_is_inf(a_in) && f32_is_inf(b_in) && (a_in[31] != b_in[31])) begin
         res = CANON_NAN;
      end
      if (f32_is_nan(a_in) || f32_is_nan(b_in)) begin
         res = CANON_NAN;
      end
      return res;
   endfunction

endpackage

[design/compensated_float_accumulator_unit.sv]
// Kahan (compensated) binary32 accumulator, top level.
// Depends on cfa_pkg for word types and the binary32 adder.
//
// Usage: req_ carries one word per sample: sample_bits and restart. restart
// clears sum and compensation to +0 before the sample is added. rsp_ gives
// one word per sample: the updated sum and compensation bit patterns.
// The result is registered and appears in the cycle after the sample is taken.
// Throughput: one sample per cycle while the receiver takes results; the four
// chained binary32 additions of a step sit between the state registers and the
// result register, and the state feeds back through them combinationally.
// While the receiver stalls, the result register holds its word and
// req_ready stays high only while the register is empty.
// Reset clears sum and compensation to +0 and empties the result register.
module compensated_float_accumulator_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cfa_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cfa_pkg::rsp_word_type rsp_data
);
   import cfa_pkg::*;

   logic [31:0]  sum_ff, comp_ff, sum_in, comp_in;
   logic [31:0]  s_use, c_use, y, t, tmp;
   logic         valid_ff;
   rsp_word_type rsp_ff;
   logic         take;

   assign req_ready = !valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      s_use   = req_data.restart ? POS_ZERO : sum_ff;
      c_use   = req_data.restart ? POS_ZERO : comp_ff;
      y       = f32_add(req_data.sample_bits, c_use ^ SIGN_BIT);
      t       = f32_add(s_use, y);
      tmp     = f32_add(t, s_use ^ SIGN_BIT);
      sum_in  = t;
      comp_in = f32_add(tmp, y ^ SIGN_BIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= POS_ZERO;
         comp_ff  <= POS_ZERO;
         valid_ff <= 1'b0;
      end else begin
         if (take) begin
            sum_ff   <= sum_in;
            comp_ff  <= comp_in;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff.sum_bits          <= sum_in;
         rsp_ff.compensation_bits <= comp_in;
      end
   end

`ifndef ASSERT_OFF
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word lost under stall");
   a_track: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_data.sum_bits == sum_ff && rsp_data.compensation_bits == comp_ff)
      else $error("result differs from state");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("stalled while empty");
`endif

endmodule
